>>> rtl/trajectory_speed_limit_checker_assert.svh
// Assertion macros shared by the trajectory speed limit checker modules.
`ifndef TRAJECTORY_SPEED_LIMIT_CHECKER_ASSERT_SVH
`define TRAJECTORY_SPEED_LIMIT_CHECKER_ASSERT_SVH

// Condition and consequence in the same cycle.
`define TSLC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequence in the cycle after the condition.
`define TSLC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/tslc_pkg.sv
// Types and constants shared by the trajectory speed limit checker.
`default_nettype none

package tslc_pkg;

  typedef enum logic [3:0] {
    S_IDLE,
    S_M_AXX,
    S_M_AYY,
    S_M_V,
    S_M_W,
    S_M_VLL,
    S_M_VHL,
    S_M_VHH,
    S_M_LAST,
    S_FIN_CALC,
    S_FIN_TIME,
    S_FIN_SKIP
  } state_t;

  // Operand pair fed to the shared multiplier.
  typedef enum logic [2:0] {
    MS_NONE,
    MS_AXX,
    MS_AYY,
    MS_V,
    MS_W,
    MS_VLL,
    MS_VHL,
    MS_VHH
  } mul_sel_t;

  // Destination of the registered product from the previous cycle.
  typedef enum logic [2:0] {
    AC_NONE,
    AC_DIST0,
    AC_DIST1,
    AC_V,
    AC_W,
    AC_LIM0,
    AC_LIM1,
    AC_LIM2
  } acc_sel_t;

  // Where the new held verdict comes from when an item finishes.
  typedef enum logic [1:0] {
    VS_KEEP,
    VS_TIME,
    VS_CALC
  } vsrc_t;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LINEAR_SPEED = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TURN_RATE    = 1'b1;

  localparam logic [15:0] MLS_RESET = 16'd256;
  localparam logic [31:0] MTR_RESET = 32'd175000;

  localparam logic [1:0] VERDICT_OK      = 2'd0;
  localparam logic [1:0] VERDICT_TIME    = 2'd1;
  localparam logic [1:0] VERDICT_LINEAR  = 2'd2;
  localparam logic [1:0] VERDICT_ANGULAR = 2'd3;

  typedef struct packed {
    logic     load;
    mul_sel_t mul_sel;
    acc_sel_t acc_sel;
    logic     fin;
    vsrc_t    vsrc;
  } dp_cmd_t;

  typedef struct packed {
    logic skip;
    logic time_fail;
    logic fin_wait;
  } dp_status_t;

endpackage

`default_nettype wire

>>> rtl/tslc_datapath.sv
// Datapath: point registers, shared multiplier, accumulators, compares and result register.
`default_nettype none

module tslc_datapath (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  wire                                    cfg_we,
  input  wire        [tslc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire        [tslc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire signed [31:0]                      in_pos_x,
  input  wire signed [31:0]                      in_pos_y,
  input  wire        [15:0]                      in_heading,
  input  wire        [31:0]                      in_time_us,
  input  wire                                    in_first,
  input  wire                                    in_last,
  input  wire                                    out_stall,
  output logic                                   out_valid,
  output logic       [1:0]                       out_verdict,
  input  tslc_pkg::dp_cmd_t                      cmd,
  output tslc_pkg::dp_status_t                   status
);
  import tslc_pkg::*;

  logic [15:0] mls_r;
  logic [31:0] mtr_r;

  logic [31:0] prev_x_r, prev_y_r, prev_time_r;
  logic [15:0] prev_heading_r;
  logic [1:0]  held_r;

  logic [31:0] x_r, y_r, t_r, ax_r, ay_r, dt_r;
  logic [15:0] h_r, turn_r;
  logic        first_r, last_r;

  logic [63:0] prod_r;
  logic [64:0] dist_r;
  logic [47:0] v_r;
  logic [63:0] wlim_r;
  logic [95:0] lim_r;

  logic        out_valid_r;
  logic [1:0]  out_verdict_r;

  logic [32:0] dx, dy;
  logic [31:0] ax, ay;
  logic [15:0] dh, turn;
  logic [31:0] mul_a, mul_b;
  logic        lin_fail, ang_fail, fin_go;
  logic [1:0]  verdict_nxt;

  // Differences of two signed 32-bit values need 33 bits; their magnitude fits in 32.
  always_comb begin
    dx   = {in_pos_x[31], in_pos_x} - {prev_x_r[31], prev_x_r};
    dy   = {in_pos_y[31], in_pos_y} - {prev_y_r[31], prev_y_r};
    ax   = dx[32] ? 32'(-dx) : dx[31:0];
    ay   = dy[32] ? 32'(-dy) : dy[31:0];
    dh   = in_heading - prev_heading_r;
    turn = dh[15] ? 16'(17'h10000 - {1'b0, dh}) : dh;
  end

  assign status.skip      = in_first || (held_r != VERDICT_OK);
  assign status.time_fail = (in_time_us <= prev_time_r);
  assign status.fin_wait  = last_r && out_valid_r && out_stall;

  assign fin_go = cmd.fin && !status.fin_wait;

  always_comb begin
    case (cmd.mul_sel)
      MS_AXX: begin mul_a = ax_r;                    mul_b = ax_r;                    end
      MS_AYY: begin mul_a = ay_r;                    mul_b = ay_r;                    end
      MS_V:   begin mul_a = {16'b0, mls_r};          mul_b = dt_r;                    end
      MS_W:   begin mul_a = mtr_r;                   mul_b = dt_r;                    end
      MS_VLL: begin mul_a = {8'b0, v_r[23:0]};       mul_b = {8'b0, v_r[23:0]};       end
      MS_VHL: begin mul_a = {8'b0, v_r[47:24]};      mul_b = {8'b0, v_r[23:0]};       end
      MS_VHH: begin mul_a = {8'b0, v_r[47:24]};      mul_b = {8'b0, v_r[47:24]};      end
      default: begin mul_a = '0;                     mul_b = '0;                      end
    endcase
  end

  always_comb begin
    lin_fail = {15'b0, dist_r, 16'b0} > lim_r;
    ang_fail = {24'b0, turn_r, 24'b0} > wlim_r;
    case (cmd.vsrc)
      VS_KEEP: verdict_nxt = first_r ? VERDICT_OK : held_r;
      VS_TIME: verdict_nxt = VERDICT_TIME;
      VS_CALC: verdict_nxt = lin_fail ? VERDICT_LINEAR :
                             (ang_fail ? VERDICT_ANGULAR : VERDICT_OK);
      default: verdict_nxt = held_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mls_r          <= MLS_RESET;
      mtr_r          <= MTR_RESET;
      prev_x_r       <= '0;
      prev_y_r       <= '0;
      prev_heading_r <= '0;
      prev_time_r    <= '0;
      held_r         <= VERDICT_OK;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MAX_LINEAR_SPEED: mls_r <= cfg_data[15:0];
          CFG_MAX_TURN_RATE:    mtr_r <= cfg_data[31:0];
          default: ;
        endcase
      end
      if (fin_go && last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (fin_go) begin
        held_r         <= verdict_nxt;
        prev_x_r       <= x_r;
        prev_y_r       <= y_r;
        prev_heading_r <= h_r;
        prev_time_r    <= t_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r     <= in_pos_x;
      y_r     <= in_pos_y;
      h_r     <= in_heading;
      t_r     <= in_time_us;
      first_r <= in_first;
      last_r  <= in_last;
      ax_r    <= ax;
      ay_r    <= ay;
      dt_r    <= in_time_us - prev_time_r;
      turn_r  <= turn;
    end
    prod_r <= mul_a * mul_b;
    case (cmd.acc_sel)
      AC_DIST0: dist_r <= {1'b0, prod_r};
      AC_DIST1: dist_r <= dist_r + {1'b0, prod_r};
      AC_V:     v_r    <= prod_r[47:0];
      AC_W:     wlim_r <= prod_r;
      AC_LIM0:  lim_r  <= {32'b0, prod_r};
      AC_LIM1:  lim_r  <= lim_r + {23'b0, prod_r[47:0], 25'b0};
      AC_LIM2:  lim_r  <= lim_r + {prod_r[47:0], 48'b0};
      default: ;
    endcase
    if (fin_go && last_r) begin
      out_verdict_r <= verdict_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_verdict = out_verdict_r;

`include "trajectory_speed_limit_checker_assert.svh"

  `TSLC_ASSERT_NEXT(a_held_only_at_finish, clk, rst_n, !fin_go, $stable(held_r), "held verdict changed outside finish")
  `TSLC_ASSERT_NEXT(a_first_clears, clk, rst_n, fin_go && first_r, held_r == VERDICT_OK, "first point did not clear verdict")
  `TSLC_ASSERT_NEXT(a_last_emits_held, clk, rst_n, fin_go && last_r, out_valid_r && (out_verdict_r == held_r), "last point result does not match held verdict")

endmodule

`default_nettype wire

>>> rtl/tslc_controller.sv
// Controller: sequences the shared multiplier and finishes each item.
`default_nettype none

module tslc_controller (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  tslc_pkg::dp_status_t  status,
  output tslc_pkg::dp_cmd_t     cmd
);
  import tslc_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd.load    = 1'b0;
    cmd.mul_sel = MS_NONE;
    cmd.acc_sel = AC_NONE;
    cmd.fin     = 1'b0;
    cmd.vsrc    = VS_KEEP;
    in_stall    = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (status.skip) begin
            state_nxt = S_FIN_SKIP;
          end else if (status.time_fail) begin
            state_nxt = S_FIN_TIME;
          end else begin
            state_nxt = S_M_AXX;
          end
        end
      end
      S_M_AXX: begin
        cmd.mul_sel = MS_AXX;
        state_nxt   = S_M_AYY;
      end
      S_M_AYY: begin
        cmd.mul_sel = MS_AYY;
        cmd.acc_sel = AC_DIST0;
        state_nxt   = S_M_V;
      end
      S_M_V: begin
        cmd.mul_sel = MS_V;
        cmd.acc_sel = AC_DIST1;
        state_nxt   = S_M_W;
      end
      S_M_W: begin
        cmd.mul_sel = MS_W;
        cmd.acc_sel = AC_V;
        state_nxt   = S_M_VLL;
      end
      S_M_VLL: begin
        cmd.mul_sel = MS_VLL;
        cmd.acc_sel = AC_W;
        state_nxt   = S_M_VHL;
      end
      S_M_VHL: begin
        cmd.mul_sel = MS_VHL;
        cmd.acc_sel = AC_LIM0;
        state_nxt   = S_M_VHH;
      end
      S_M_VHH: begin
        cmd.mul_sel = MS_VHH;
        cmd.acc_sel = AC_LIM1;
        state_nxt   = S_M_LAST;
      end
      S_M_LAST: begin
        cmd.acc_sel = AC_LIM2;
        state_nxt   = S_FIN_CALC;
      end
      S_FIN_CALC, S_FIN_TIME, S_FIN_SKIP: begin
        cmd.fin  = 1'b1;
        cmd.vsrc = (state_r == S_FIN_CALC) ? VS_CALC :
                   ((state_r == S_FIN_TIME) ? VS_TIME : VS_KEEP);
        if (!status.fin_wait) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

`include "trajectory_speed_limit_checker_assert.svh"

  `TSLC_ASSERT_NEXT(a_load_leaves_idle, clk, rst_n, cmd.load, state_r != S_IDLE, "controller stayed idle after taking an item")
  `TSLC_ASSERT_NEXT(a_wait_holds_finish, clk, rst_n, cmd.fin && status.fin_wait, $stable(state_r), "finish left while result slot busy")
  `TSLC_ASSERT_NEXT(a_finish_returns_idle, clk, rst_n, cmd.fin && !status.fin_wait, state_r == S_IDLE, "finish did not return to idle")

endmodule

`default_nettype wire

>>> rtl/trajectory_speed_limit_checker.sv
// Top level of the trajectory speed limit checker: controller plus datapath.
//
//   Channel  Direction  Handshake             Payload
//   in       input      in_valid / in_stall   in_pos_x, in_pos_y, in_heading, in_time_us,
//                                             in_first, in_last
//   out      output     out_valid / out_stall out_verdict
//   cfg      input      cfg_we                cfg_index, cfg_data
//
// A point that is checked passes a state that takes the item, seven products on the single
// shared 32x32 multiplier, a state to fold in the last product and a finish state to compare.
// A first point, one after a held failure or one whose time does not increase goes to finish.
// Reset restores the limit registers to their defaults, zeroes the previous point and sets
// the held verdict to accepted. A result waits in an output register, so a stalled result
// only holds up the next point marked last, at its final cycle.
`default_nettype none

module trajectory_speed_limit_checker (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  wire                                    cfg_we,
  input  wire        [tslc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire        [tslc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire                                    in_valid,
  output logic                                   in_stall,
  input  wire signed [31:0]                      in_pos_x,
  input  wire signed [31:0]                      in_pos_y,
  input  wire        [15:0]                      in_heading,
  input  wire        [31:0]                      in_time_us,
  input  wire                                    in_first,
  input  wire                                    in_last,
  output logic                                   out_valid,
  input  wire                                    out_stall,
  output logic       [1:0]                       out_verdict
);
  import tslc_pkg::*;

  // Commands from the controller and status back from the datapath.
  dp_cmd_t    cmd;
  dp_status_t status;

  // The controller takes an item only when idle; the datapath captures it on cmd.load
  // and reports whether the segment check can be skipped or fails on time alone.
  tslc_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath squares the distance, forms (speed limit * dt)^2 from 24-bit halves,
  // forms turn rate limit * dt, and compares all of them exactly in the finish cycle.
  tslc_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_pos_x    (in_pos_x),
    .in_pos_y    (in_pos_y),
    .in_heading  (in_heading),
    .in_time_us  (in_time_us),
    .in_first    (in_first),
    .in_last     (in_last),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_verdict (out_verdict),
    .cmd         (cmd),
    .status      (status)
  );

endmodule

`default_nettype wire
